### rtl/hev_pkg.sv
// hev_pkg: widths, result type and constant position tables for the
// variable-length Hamming encoder. No dependencies.
package hev_pkg;

    localparam int HEV_MAX_DATA_BITS = 57;
    localparam int HEV_LEN_W         = 6;
    localparam int HEV_CODE_W        = 64;
    localparam int HEV_CODE_LEN_W    = 7;
    localparam int HEV_PAR_MAX       = 7;
    localparam int HEV_PAR_CNT_W     = 3;

    typedef struct packed {
        logic [HEV_CODE_W-1:0]     code_bits;
        logic [HEV_CODE_LEN_W-1:0] code_length;
    } hev_result_t;

    function automatic bit is_pow2(input int v);
        return (v != 0) && ((v & (v - 1)) == 0);
    endfunction

    // Data bit held by a non-power-of-two position p (1-based):
    // p minus the number of powers of two at or below p, minus one.
    function automatic int data_index(input int p);
        int pw;
        pw = 0;
        for (int k = 0; k < HEV_PAR_MAX; k++) begin
            if ((1 << k) <= p) begin
                pw++;
            end
        end
        return p - pw - 1;
    endfunction

    // Bit p-1 set for each position p covered by parity 2^k, the parity
    // position itself excluded.
    function automatic logic [HEV_CODE_W-1:0] cover_mask(input int k);
        logic [HEV_CODE_W-1:0] mask;
        mask = '0;
        for (int p = 1; p <= HEV_CODE_W; p++) begin
            if (((p >> k) & 1) == 1 && p != (1 << k)) begin
                mask[p-1] = 1'b1;
            end
        end
        return mask;
    endfunction

endpackage

### rtl/hev_encode.sv
// hev_encode: combinational Hamming encoding of one registered data word.
// Depends on hev_pkg.
module hev_encode #(
    parameter int MAX_DATA_BITS = hev_pkg::HEV_MAX_DATA_BITS
) (
    input  logic [hev_pkg::HEV_LEN_W-1:0] data_length,
    input  logic [MAX_DATA_BITS-1:0]      data_bits,
    output hev_pkg::hev_result_t          result
);
    import hev_pkg::*;

    localparam logic [HEV_LEN_W-1:0] MaxLen = HEV_LEN_W'(MAX_DATA_BITS);

    logic [HEV_LEN_W-1:0]      m_sat;
    logic [HEV_PAR_CNT_W-1:0]  r_cnt;
    logic [HEV_CODE_LEN_W-1:0] n_len;
    logic [HEV_CODE_W-1:0]     code_pre;
    logic [HEV_CODE_W-1:0]     code_out;

    assign m_sat = (data_length > MaxLen) ? MaxLen : data_length;

    // r is the count of k with 2^k < m + k + 1 (the test is monotone in k).
    always_comb begin
        r_cnt = '0;
        for (int k = 0; k < HEV_PAR_MAX; k++) begin
            if ((HEV_CODE_LEN_W'(1) << k) <
                (HEV_CODE_LEN_W'(m_sat) + HEV_CODE_LEN_W'(k) + HEV_CODE_LEN_W'(1))) begin
                r_cnt = r_cnt + HEV_PAR_CNT_W'(1);
            end
        end
    end

    assign n_len = HEV_CODE_LEN_W'(m_sat) + HEV_CODE_LEN_W'(r_cnt);

    // Data placement is a fixed wiring; positions past n are masked off.
    always_comb begin
        code_pre = '0;
        for (int p = 1; p <= HEV_CODE_W; p++) begin
            if (!is_pow2(p) && data_index(p) < MAX_DATA_BITS) begin
                code_pre[p-1] = data_bits[data_index(p)] &
                                (HEV_CODE_LEN_W'(p) <= n_len);
            end
        end
    end

    always_comb begin
        code_out = code_pre;
        for (int k = 0; k < HEV_PAR_MAX; k++) begin
            if (HEV_PAR_CNT_W'(k) < r_cnt) begin
                code_out[(1 << k) - 1] = ^(code_pre & cover_mask(k));
            end
        end
    end

    assign result.code_bits   = code_out;
    assign result.code_length = n_len;

endmodule

### rtl/hamming_encoder_variable_length.sv
// hamming_encoder_variable_length: top level, input register, encoder core,
// result register and handshake. Depends on hev_pkg and hev_encode.
//
// Even-parity Hamming encoder for data words of 0 to MAX_DATA_BITS bits.
// Each transaction carries a word and its length; the block adds the
// smallest number r of parity bits with 2^r >= m + r + 1 and returns the
// codeword with its length m + r. Bit p-1 of m_code_bits holds Hamming
// position p; bits at and above m_code_length are zero, and a length above
// MAX_DATA_BITS is clamped to it. Throughput is one transaction per clock
// while m_ready is not held low: the encode logic sits between an input
// register and a result register, and m_valid rises once a word has moved
// from the input register into the result register. Backpressure on the
// result channel stalls the input only once both registers are full.
module hamming_encoder_variable_length #(
    parameter int MAX_DATA_BITS = hev_pkg::HEV_MAX_DATA_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [hev_pkg::HEV_LEN_W-1:0]       s_data_length,
    input  logic [MAX_DATA_BITS-1:0]            s_data_bits,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hev_pkg::HEV_CODE_W-1:0]      m_code_bits,
    output logic [hev_pkg::HEV_CODE_LEN_W-1:0]  m_code_length
);
    import hev_pkg::*;

    // input stage
    logic                     in_valid_reg, in_valid_next;
    logic [HEV_LEN_W-1:0]     in_len_reg;
    logic [MAX_DATA_BITS-1:0] in_data_reg;

    // result stage
    logic        out_valid_reg, out_valid_next;
    hev_result_t out_res_reg;
    hev_result_t enc_res;

    logic s_accept;
    logic advance;

    // result stage can take a new word when empty or being drained
    assign advance  = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    hev_encode #(
        .MAX_DATA_BITS(MAX_DATA_BITS)
    ) u_encode (
        .data_length(in_len_reg),
        .data_bits  (in_data_reg),
        .result     (enc_res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_len_reg  <= s_data_length;
            in_data_reg <= s_data_bits;
        end
        if (advance && in_valid_reg) begin
            out_res_reg <= enc_res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_code_bits   = out_res_reg.code_bits;
    assign m_code_length = out_res_reg.code_length;

`ifndef SYNTH
    // nothing above the codeword length may be set
    a_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_code_bits >> m_code_length) == '0))
        else $error("code bits set above code length");

    // a codeword is empty or has at least three positions
    a_len_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_code_length != HEV_CODE_LEN_W'(1) &&
                     m_code_length != HEV_CODE_LEN_W'(2)))
        else $error("impossible code length");

    // input held off only when both stages are full and output stalled
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

    // a stalled result does not change under it
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_res_reg)))
        else $error("stalled result changed");
`endif

endmodule

### test/tb_hamming_encoder_variable_length.sv
// tb_hamming_encoder_variable_length: self-checking testbench for the
// variable-length even-parity Hamming encoder, with its own codeword predictor.
// Depends on hev_pkg and hamming_encoder_variable_length.
module tb_hamming_encoder_variable_length;
    import hev_pkg::*;

    localparam int DATA_W       = HEV_MAX_DATA_BITS;
    localparam int LEN_MAX      = (1 << HEV_LEN_W) - 1;
    localparam int NUM_RANDOM   = 1700;
    localparam int DRAIN_CYCLES = 10;   // two-stage pipe, plenty of margin
    localparam int RX_HOLD      = 300;

    // One stimulus row; want is only meaningful when has_want is set.
    typedef struct packed {
        logic [HEV_LEN_W-1:0] len;
        logic [DATA_W-1:0]    data;
        logic                 has_want;
        hev_result_t          want;
    } word_row_t;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic [HEV_LEN_W-1:0]      s_data_length = '0;
    logic [DATA_W-1:0]         s_data_bits   = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic [HEV_CODE_W-1:0]     m_code_bits;
    logic [HEV_CODE_LEN_W-1:0] m_code_length;

    hev_result_t codeword_q[$];      // expected codewords, oldest first
    int          mismatch_count = 0;
    bit          no_idle        = 1'b0;  // both sides run back to back
    int          rx_hold_cycles = 0;     // one-shot long stall request

    hamming_encoder_variable_length dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_length (s_data_length),
        .s_data_bits   (s_data_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_bits   (m_code_bits),
        .m_code_length (m_code_length)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Codeword predictor. Length clamps to DATA_W; r is the smallest parity
    // count with 2^r >= m + r + 1. Data fills non-power-of-two positions
    // from the bottom up (data bit 0 at position 3), then each parity bit
    // 2^k takes even parity over positions <= n with bit k set.
    function automatic hev_result_t hamming_codeword(input logic [HEV_LEN_W-1:0] len_in,
                                                     input logic [DATA_W-1:0] word);
        int            m;
        int            r;
        int            n;
        int            d;
        logic          ones;
        hev_result_t   res;
        m = len_in;
        if (m > DATA_W) begin
            m = DATA_W;
        end
        r = 0;
        while (r < HEV_PAR_MAX && (1 << r) < m + r + 1) begin
            r++;
        end
        n = m + r;
        res.code_bits = '0;
        d = 0;
        for (int p = 1; p <= n; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (d < m && word[d]) begin
                    res.code_bits[p-1] = 1'b1;
                end
                d++;
            end
        end
        for (int k = 0; k < r; k++) begin
            ones = 1'b0;
            for (int p = 1; p <= n; p++) begin
                if (((p >> k) & 1) == 1 && p != (1 << k)) begin
                    ones ^= res.code_bits[p-1];
                end
            end
            res.code_bits[(1 << k) - 1] = ones;
        end
        res.code_length = n[HEV_CODE_LEN_W-1:0];
        return res;
    endfunction

    function automatic word_row_t make_row(input logic [HEV_LEN_W-1:0] len,
                                           input logic [DATA_W-1:0] data,
                                           input logic has_want,
                                           input logic [HEV_CODE_W-1:0] code,
                                           input logic [HEV_CODE_LEN_W-1:0] clen);
        word_row_t row;
        row.len              = len;
        row.data             = data;
        row.has_want         = has_want;
        row.want.code_bits   = code;
        row.want.code_length = clen;
        return row;
    endfunction

    // Offer one transaction after a random gap; record its codeword once the
    // handshake completes. Valid is left high so a zero gap runs back to back.
    task automatic offer_word(input logic [HEV_LEN_W-1:0] len,
                              input logic [DATA_W-1:0] bits,
                              input hev_result_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_length <= len;
        s_data_bits   <= bits;
        do @(posedge aclk); while (!s_ready);
        codeword_q.push_back(want);
    endtask

    // Sender: reset, directed table, then random words.
    initial begin
        word_row_t            directed_words[$];
        word_row_t            row;
        logic [HEV_LEN_W-1:0] len;
        logic [DATA_W-1:0]    bits;
        int                   pick;

        // Typed rows: empty word, one- and two-bit words, full-length words (all
        // parity set when all data is one), and clamped lengths.
        directed_words.push_back(make_row(6'd0,   {DATA_W{1'b1}}, 1'b1, 64'd0, 7'd0));
        directed_words.push_back(make_row(6'd0,   '0,             1'b1, 64'd0, 7'd0));
        directed_words.push_back(make_row(6'd1,   57'd1,          1'b1, 64'd7, 7'd3));
        directed_words.push_back(make_row(6'd1,   57'd0,          1'b1, 64'd0, 7'd3));
        directed_words.push_back(make_row(6'd2,   57'd0,          1'b1, 64'd0, 7'd5));
        directed_words.push_back(make_row(6'd57,  '0,             1'b1, 64'd0, 7'd63));
        directed_words.push_back(make_row(6'd57,  {DATA_W{1'b1}}, 1'b1,
                                          64'h7FFF_FFFF_FFFF_FFFF, 7'd63));
        directed_words.push_back(make_row(6'd63,  '0,             1'b1, 64'd0, 7'd63));
        directed_words.push_back(make_row(6'd63,  {DATA_W{1'b1}}, 1'b1,
                                          64'h7FFF_FFFF_FFFF_FFFF, 7'd63));
        // Predicted rows: parity-count boundaries, junk above the length,
        // single bits at the ends, clamped lengths with patterns.
        directed_words.push_back(make_row(6'd1,   {DATA_W{1'b1}}, 1'b0, '0, '0));
        directed_words.push_back(make_row(6'd2,   57'd3,          1'b0, '0, '0));
        directed_words.push_back(make_row(6'd4,   {DATA_W{1'b1}}, 1'b0, '0, '0));
        directed_words.push_back(make_row(6'd5,   57'h15,         1'b0, '0, '0));
        directed_words.push_back(make_row(6'd11,  57'h5A5,        1'b0, '0, '0));
        directed_words.push_back(make_row(6'd12,  57'hFFF,        1'b0, '0, '0));
        directed_words.push_back(make_row(6'd26,  57'h2AA_AAAA,   1'b0, '0, '0));
        directed_words.push_back(make_row(6'd27,  57'h555_5555,   1'b0, '0, '0));
        directed_words.push_back(make_row(6'd57,  57'd1,          1'b0, '0, '0));
        directed_words.push_back(make_row(6'd57,  57'd1 << 56,    1'b0, '0, '0));
        directed_words.push_back(make_row(6'd58,  57'h0AA_AAAA_AAAA_AAAA, 1'b0, '0, '0));
        directed_words.push_back(make_row(6'd63,  57'h155_5555_5555_5555, 1'b0, '0, '0));
        directed_words.push_back(make_row(6'd3,   57'h1FF_FFFF_FFFF_FFF8, 1'b0, '0, '0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_words[i]) begin
            row = directed_words[i];
            offer_word(row.len, row.data,
                       row.has_want ? row.want : hamming_codeword(row.len, row.data));
        end

        for (int i = 0; i < NUM_RANDOM; i++) begin
            no_idle = (i >= 400 && i < 600) || (i >= 1000 && i < 1040) ||
                      (i >= 1300 && i < 1400);
            // Sender goes quiet until the pipe has fully drained.
            if (i == 800) begin
                s_valid <= 1'b0;
                while (codeword_q.size() != 0) @(posedge aclk);
            end
            // Receiver backs off long while the sender streams: fills both
            // pipeline registers and forces s_ready low.
            if (i == 1000) begin
                rx_hold_cycles = RX_HOLD;
            end

            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                len = HEV_LEN_W'($urandom_range(0, DATA_W));
            end else if (pick == 8) begin
                len = HEV_LEN_W'($urandom_range(DATA_W + 1, LEN_MAX));
            end else begin
                len = $urandom_range(0, 1) ? HEV_LEN_W'(DATA_W) : HEV_LEN_W'(1);
            end

            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    bits = '0;
                end
                1: begin
                    bits = {DATA_W{1'b1}};
                end
                2: begin
                    bits = '0;
                    bits[$urandom_range(0, DATA_W - 1)] = 1'b1;
                end
                default: begin
                    bits = DATA_W'({$urandom, $urandom});
                end
            endcase
            offer_word(len, bits, hamming_codeword(len, bits));
        end
        s_valid <= 1'b0;

        while (codeword_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_hamming_encoder_variable_length: done, clean");
        end else begin
            $display("tb_hamming_encoder_variable_length: done, errors");
        end
        $finish;
    end

    // Receiver: random stalls per transaction, compare against the oldest
    // expected codeword.
    initial begin
        int          stall;
        hev_result_t want;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (codeword_q.size() == 0) begin
                $error("result with no transaction pending: code_bits %h code_length %0d",
                       m_code_bits, m_code_length);
                mismatch_count++;
            end else begin
                want = codeword_q.pop_front();
                if (m_code_bits !== want.code_bits) begin
                    $error("code_bits: expected %h, got %h", want.code_bits, m_code_bits);
                    mismatch_count++;
                end
                if (m_code_length !== want.code_length) begin
                    $error("code_length: expected %0d, got %0d",
                           want.code_length, m_code_length);
                    mismatch_count++;
                end
            end
        end
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("tb_hamming_encoder_variable_length: done, errors");
        $finish;
    end

endmodule

### hamming_encoder_variable_length.f
rtl/hev_pkg.sv
rtl/hev_encode.sv
rtl/hamming_encoder_variable_length.sv
test/tb_hamming_encoder_variable_length.sv
